@@ design/bpe_pkg.sv @@
// Shared constants, types and helper functions of the Bezier point evaluator.
`default_nettype none
package bpe_pkg;
	localparam int MAX_POINTS = 8;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int T_W        = 17;
	localparam int COORD_W    = 24;
	localparam int PT_W       = 2 * COORD_W;
	localparam int STEP_W     = 17;
	localparam int TS_W       = 16;
	localparam int PC_W       = 4;
	localparam int SLOT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int BINOM_W    = MAX_POINTS;
	localparam int W_W        = BINOM_W + T_W;
	localparam int PROD_W     = W_W + 1 + COORD_W;
	localparam int ACC_W      = PROD_W + IDX_W;

	typedef logic [T_W-1:0] frac_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [1:0] status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_STEP  = 2'd1;
	localparam status_t ST_NO_POINTS = 2'd2;
	localparam status_t ST_ONE_POINT = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam cfg_idx_t CFG_POINT_COUNT = 2'd0;
	localparam cfg_idx_t CFG_TOTAL_STEPS = 2'd1;
	localparam cfg_idx_t CFG_EASE_MODE   = 2'd2;

	localparam frac_t T_ONE  = frac_t'(65536);
	localparam frac_t T_HALF = frac_t'(32768);

	localparam int BTAB_W = MAX_POINTS * MAX_POINTS * BINOM_W;

	// Pascal triangle, row n holds C(n, i)
	function automatic logic [BTAB_W-1:0] build_binom();
		logic [BTAB_W-1:0] tab;
		int r [MAX_POINTS];
		tab = '0;
		for (int k = 0; k < MAX_POINTS; k++) r[k] = 0;
		r[0] = 1;
		for (int n = 0; n < MAX_POINTS; n++) begin
			for (int i = n; i >= 1; i--) r[i] = r[i] + r[i-1];
			for (int i = 0; i <= n; i++)
				tab[(n * MAX_POINTS + i) * BINOM_W +: BINOM_W] = BINOM_W'(r[i]);
		end
		return tab;
	endfunction

	localparam logic [BTAB_W-1:0] BINOM_TAB = build_binom();

	function automatic logic [BINOM_W-1:0] binom(input logic [IDX_W-1:0] n,
			input logic [IDX_W-1:0] i);
		return BINOM_TAB[(int'(n) * MAX_POINTS + int'(i)) * BINOM_W +: BINOM_W];
	endfunction

	// round half up out of Q.16 weights, then clamp to the coordinate range
	function automatic coord_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-17:0] q;
		biased = acc + $signed(ACC_W'(32768));
		q = biased[ACC_W-1:16];
		if (q > $signed((ACC_W-16)'(8388607)))
			return coord_t'(24'h7FFFFF);
		else if (q < $signed((ACC_W-16)'(-8388608)))
			return coord_t'(24'h800000);
		else
			return coord_t'(q[COORD_W-1:0]);
	endfunction
endpackage
`default_nettype wire

@@ design/bpe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bpe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ design/bpe_div.sv @@
// Radix-2 restoring divider for t = k * 65536 / total_steps, k <= total_steps.
`default_nettype none
module bpe_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bpe_pkg::TS_W-1:0]  num,
	input  wire logic [bpe_pkg::TS_W-1:0]  den,
	output logic                           done,
	output bpe_pkg::frac_t                 quot
);
	import bpe_pkg::*;

	logic              busy_q;
	logic              eq_q;
	logic [4:0]        cnt_q;
	logic [TS_W-1:0]   rem_q;
	logic [TS_W-1:0]   den_q;
	frac_t             quot_q;
	logic              done_q;
	logic [TS_W:0]     rem2;
	logic              ge;
	logic [TS_W:0]     diff;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			eq_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				eq_q   <= (num == den);
				cnt_q  <= 5'd16;
				rem_q  <= num;
				den_q  <= den;
				quot_q <= '0;
			end else if (busy_q) begin
				if (eq_q) begin
					// k equal to the step count: t is exactly one
					quot_q <= T_ONE;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rem_q  <= ge ? diff[TS_W-1:0] : rem2[TS_W-1:0];
					quot_q <= {quot_q[T_W-2:0], ge};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

@@ design/bezier_point_eval_eased.sv @@
// Bezier curve point evaluator: point store, parameter unit and Bernstein sum.
//
// Usage: a request on the input channel either loads one control point
// (mode 0: point_slot, point_x, point_y) into the point RAM, or evaluates
// the curve at step_index (mode 1). Every request yields one result on the
// output channel: curve_x, curve_y (Q16.8) and status.
// The config channel (cfg_valid/cfg_ready, always ready) writes point_count,
// total_steps and ease_mode by cfg_index; write it only while the block idles.
// A load or a rejected evaluate goes from S_IDLE through S_DONE to the output.
// An evaluate with n = count-1 runs the 16-step divider (S_DIV), then
// S_EASE1 to S_EASE3 if eased, the (1 - t) power table (S_OPOW), then
// S_PT_A to S_PT_D for each of the n+1 points, fed by the point RAM read
// port, then S_ROUND and S_DONE. One request is in work at a time; the next
// is taken as soon as the result sits in the output register.
// Stall: the output register holds its result until taken; a finished
// result waits inside the block until the output register frees.
// Reset clears the registers (count 0, total_steps 1, linear); the point
// RAM is not cleared and points read must have been loaded.
`default_nettype none
module bezier_point_eval_eased (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              mode,
	input  wire logic [bpe_pkg::SLOT_W-1:0]        point_slot,
	input  wire logic signed [bpe_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [bpe_pkg::COORD_W-1:0] point_y,
	input  wire logic signed [bpe_pkg::STEP_W-1:0] step_index,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output bpe_pkg::coord_t                        curve_x,
	output bpe_pkg::coord_t                        curve_y,
	output bpe_pkg::status_t                       status,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire bpe_pkg::cfg_idx_t                 cfg_index,
	input  wire logic [bpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bpe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_EASE1, S_EASE2, S_EASE3, S_OPOW,
		S_PT_A, S_PT_B, S_PT_C, S_PT_D, S_ROUND, S_DONE
	} state_t;

	state_t              state_q;
	logic [PC_W-1:0]     pcount_q;
	logic [TS_W-1:0]     tsteps_q;
	logic                ease_q;

	frac_t               t_q;
	logic                ge_q;
	logic [2*T_W-1:0]    sq_q;
	frac_t               run_q;
	frac_t               opw_q [MAX_POINTS];
	logic [IDX_W:0]      j_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    i_q;
	frac_t               tp_q;
	logic [2*T_W-1:0]    prod_q;
	logic [W_W-1:0]      w_q;
	logic signed [PROD_W-1:0] px_q;
	logic signed [PROD_W-1:0] py_q;
	logic signed [ACC_W-1:0]  acc_x_q;
	logic signed [ACC_W-1:0]  acc_y_q;
	coord_t              res_x_q;
	coord_t              res_y_q;
	status_t             res_st_q;
	coord_t              curve_x_q;
	coord_t              curve_y_q;
	status_t             status_q;
	logic                out_valid_q;

	logic                accept;
	logic                bad_step;
	logic [CNT_W-1:0]    cnt;
	logic                div_start;
	logic                div_done;
	frac_t               div_quot;
	logic                ease_ge;
	logic [T_W:0]        u_full;
	frac_t               ease_base;
	logic [2*T_W-1:0]    ease_sq;
	logic [2*T_W-1:0]    ease_sq2;
	frac_t               om;
	logic [2*T_W-1:0]    opow_prod;
	logic [2*T_W-1:0]    pair_prod;
	logic [2*T_W-1:0]    tp_prod;
	logic [IDX_W-1:0]    opw_idx;
	logic                ram_we;
	logic                ram_re;
	logic [PT_W-1:0]     ram_rdata;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign bad_step = (tsteps_q == '0) || step_index[STEP_W-1]
		|| (step_index[TS_W-1:0] > tsteps_q) || step_index[TS_W];
	assign cnt = (int'(pcount_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(pcount_q);
	assign div_start = accept && (mode == MODE_EVAL) && !bad_step && (cnt > CNT_W'(1));

	// ease: below one half square t twice, above it fold to u = 2 - 2t
	assign ease_ge   = t_q[T_W-1] | t_q[T_W-2];
	assign u_full    = {1'b1, {T_W{1'b0}}} - {t_q, 1'b0};
	assign ease_base = ease_ge ? u_full[T_W-1:0] : t_q;
	assign ease_sq   = ease_base * ease_base;
	assign ease_sq2  = sq_q[32:16] * sq_q[32:16];

	assign om        = T_ONE - t_q;
	assign opow_prod = run_q * om;
	assign opw_idx   = n_q - i_q;
	assign pair_prod = tp_q * opw_q[opw_idx];
	assign tp_prod   = tp_q * t_q;

	assign ram_we = accept && (mode == MODE_LOAD) && (int'(point_slot) < MAX_POINTS);
	assign ram_re = (state_q == S_PT_A);

	bpe_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(point_slot)),
		.wdata ({point_x, point_y}),
		.re    (ram_re),
		.raddr (i_q),
		.rdata (ram_rdata)
	);

	bpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (step_index[TS_W-1:0]),
		.den    (tsteps_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pcount_q    <= '0;
			tsteps_q    <= TS_W'(1);
			ease_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_POINT_COUNT: pcount_q <= cfg_data[PC_W-1:0];
					CFG_TOTAL_STEPS: tsteps_q <= cfg_data[TS_W-1:0];
					CFG_EASE_MODE:   ease_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_x_q <= '0;
						res_y_q <= '0;
						n_q     <= IDX_W'(cnt - CNT_W'(1));
						if (mode == MODE_LOAD) begin
							res_st_q <= ST_OK;
							state_q  <= S_DONE;
						end else if (bad_step) begin
							res_st_q <= ST_BAD_STEP;
							state_q  <= S_DONE;
						end else if (cnt == '0) begin
							res_st_q <= ST_NO_POINTS;
							state_q  <= S_DONE;
						end else if (cnt == CNT_W'(1)) begin
							res_st_q <= ST_ONE_POINT;
							state_q  <= S_DONE;
						end else begin
							res_st_q <= ST_OK;
							state_q  <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						t_q <= div_quot;
						if (ease_q) begin
							state_q <= S_EASE1;
						end else begin
							state_q <= S_OPOW;
						end
						run_q    <= T_ONE;
						opw_q[0] <= T_ONE;
						j_q      <= (IDX_W+1)'(1);
					end
				end
				S_EASE1: begin
					ge_q    <= ease_ge;
					sq_q    <= ease_sq;
					state_q <= S_EASE2;
				end
				S_EASE2: begin
					sq_q    <= ease_sq2;
					state_q <= S_EASE3;
				end
				S_EASE3: begin
					t_q     <= ge_q ? T_ONE - {1'b0, sq_q[32:17]} : {sq_q[29:16], 3'b000};
					state_q <= S_OPOW;
				end
				S_OPOW: begin
					// powers of (1 - t) into the small weight table
					if (j_q > {1'b0, n_q}) begin
						tp_q    <= T_ONE;
						i_q     <= '0;
						acc_x_q <= '0;
						acc_y_q <= '0;
						state_q <= S_PT_A;
					end else begin
						opw_q[j_q[IDX_W-1:0]] <= opow_prod[32:16];
						run_q   <= opow_prod[32:16];
						j_q     <= j_q + (IDX_W+1)'(1);
					end
				end
				S_PT_A: begin
					prod_q  <= pair_prod;
					state_q <= S_PT_B;
				end
				S_PT_B: begin
					w_q     <= binom(n_q, i_q) * prod_q[32:16];
					tp_q    <= tp_prod[32:16];
					state_q <= S_PT_C;
				end
				S_PT_C: begin
					px_q    <= $signed({1'b0, w_q}) * $signed(ram_rdata[PT_W-1:COORD_W]);
					py_q    <= $signed({1'b0, w_q}) * $signed(ram_rdata[COORD_W-1:0]);
					state_q <= S_PT_D;
				end
				S_PT_D: begin
					acc_x_q <= acc_x_q + ACC_W'(px_q);
					acc_y_q <= acc_y_q + ACC_W'(py_q);
					if (i_q == n_q) begin
						state_q <= S_ROUND;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_PT_A;
					end
				end
				S_ROUND: begin
					res_x_q <= round_sat(acc_x_q);
					res_y_q <= round_sat(acc_y_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						curve_x_q   <= res_x_q;
						curve_y_q   <= res_y_q;
						status_q    <= res_st_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign curve_x   = curve_x_q;
	assign curve_y   = curve_y_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("point RAM read and write in the same cycle");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second request taken while one is in work");

	a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (curve_x == '0) && (curve_y == '0))
		else $error("error status with nonzero coordinates");
`endif
endmodule
`default_nettype wire
